[design/lbat_pkg.sv]
`timescale 1ns / 1ps
// lbat_pkg: shared widths, type codes, register indexes and latencies
// for the layer box pipeline; no dependencies

package lbat_pkg;

    localparam int TIME_W   = 24;
    localparam int SPAN_W   = 26;
    localparam int POS_W    = 16;
    localparam int EXT_W    = 16;
    localparam int BOX_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam int INTERP_DIV_STEPS = 16;
    localparam int INTERP_LAT       = INTERP_DIV_STEPS + 2;
    localparam int SCALE_DIV_STEPS  = 32;
    localparam int SCALE_LAT        = SCALE_DIV_STEPS + 2;

    localparam logic [2:0] OBJ_EMPTY      = 3'd0;
    localparam logic [2:0] OBJ_IMAGE      = 3'd1;
    localparam logic [2:0] OBJ_BACKGROUND = 3'd2;
    localparam logic [2:0] OBJ_HIGHLIGHT  = 3'd3;
    localparam logic [2:0] OBJ_MOUSE      = 3'd4;
    localparam logic [2:0] OBJ_TEXT       = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_PROJECT_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROJECT_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_H    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR    = 3'd4;

endpackage

[design/lbat_interp.sv]
`timescale 1ns / 1ps
// lbat_interp: pipelined linear interpolation, multiply then a
// restoring divider one quotient bit per stage; uses lbat_pkg

module lbat_interp (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [lbat_pkg::POS_W-1:0]   a,
    input  logic signed [lbat_pkg::POS_W-1:0]   b,
    input  logic        [lbat_pkg::TIME_W-1:0]  t,
    input  logic        [lbat_pkg::SPAN_W-1:0]  span,
    output logic signed [lbat_pkg::POS_W-1:0]   pos
);

    localparam int STEPS = lbat_pkg::INTERP_DIV_STEPS;
    localparam int REM_W = lbat_pkg::POS_W + lbat_pkg::SPAN_W + 1;
    localparam int PT_W  = lbat_pkg::POS_W + lbat_pkg::TIME_W + 2;

    logic signed [REM_W-1:0]            p_span_reg;
    logic signed [PT_W-1:0]             p_t_reg;
    logic        [lbat_pkg::SPAN_W-1:0] m_span_reg;
    logic signed [lbat_pkg::POS_W-1:0]  m_a_reg;

    logic signed [lbat_pkg::POS_W:0]    diff;
    logic signed [lbat_pkg::SPAN_W:0]   span_s;
    logic signed [lbat_pkg::TIME_W:0]   t_s;
    logic signed [REM_W:0]              n_sum;
    logic        [REM_W:0]              n_mag;

    logic        [REM_W-1:0]            rem_reg  [0:STEPS];
    logic        [STEPS-1:0]            q_reg    [0:STEPS];
    logic        [lbat_pkg::SPAN_W-1:0] span_reg [0:STEPS];
    logic                               neg_reg  [0:STEPS];
    logic signed [lbat_pkg::POS_W-1:0]  a_reg    [0:STEPS];

    logic signed [lbat_pkg::POS_W:0]    q_signed;

    assign diff   = {b[lbat_pkg::POS_W-1], b} - {a[lbat_pkg::POS_W-1], a};
    assign span_s = {1'b0, span};
    assign t_s    = {1'b0, t};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_span_reg <= a * span_s;
            p_t_reg    <= diff * t_s;
            m_span_reg <= span;
            m_a_reg    <= a;
        end
    end

    assign n_sum = {p_span_reg[REM_W-1], p_span_reg}
                 + {{(REM_W + 1 - PT_W){p_t_reg[PT_W-1]}}, p_t_reg};
    assign n_mag = n_sum[REM_W] ? (~n_sum + 1'b1) : n_sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= n_mag[REM_W-1:0];
            q_reg[0]    <= '0;
            span_reg[0] <= m_span_reg;
            neg_reg[0]  <= n_sum[REM_W];
            a_reg[0]    <= m_a_reg;
        end
    end

    for (genvar i = 1; i <= STEPS; i++)
    begin : g_div
        localparam int K = STEPS - i;
        logic [REM_W-1:0] sub;
        logic             take;

        assign sub  = {{(REM_W - lbat_pkg::SPAN_W){1'b0}}, span_reg[i-1]} << K;
        assign take = (rem_reg[i-1] >= sub);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= take ? (rem_reg[i-1] - sub) : rem_reg[i-1];
                q_reg[i]    <= q_reg[i-1] | (STEPS'(take) << K);
                span_reg[i] <= span_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
                a_reg[i]    <= a_reg[i-1];
            end
        end
    end

    assign q_signed = neg_reg[STEPS] ? -$signed({1'b0, q_reg[STEPS]})
                                     : $signed({1'b0, q_reg[STEPS]});
    assign pos = (span_reg[STEPS] == '0) ? a_reg[STEPS]
                                         : q_signed[lbat_pkg::POS_W-1:0];

endmodule

[design/lbat_scale.sv]
`timescale 1ns / 1ps
// lbat_scale: pipelined scale by view/project extent with round half away
// from zero, restoring divider one quotient bit per stage; uses lbat_pkg

module lbat_scale (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [lbat_pkg::POS_W:0]    val,
    input  logic        [lbat_pkg::EXT_W-1:0]  mul,
    input  logic        [lbat_pkg::EXT_W-1:0]  div,
    output logic        [lbat_pkg::BOX_W-1:0]  mag,
    output logic                               neg
);

    localparam int STEPS  = lbat_pkg::SCALE_DIV_STEPS;
    localparam int PROD_W = 2 * (lbat_pkg::EXT_W + 1);
    localparam int REM_W  = PROD_W + 1;
    localparam int DV_W   = lbat_pkg::EXT_W + 1;
    localparam int CMP_W  = DV_W + STEPS;

    logic signed [PROD_W-1:0]          prod_reg;
    logic        [lbat_pkg::EXT_W-1:0] m_div_reg;
    logic signed [lbat_pkg::EXT_W:0]   mul_s;
    logic        [PROD_W-1:0]          prod_mag;

    logic [REM_W-1:0] rem_reg [0:STEPS];
    logic [STEPS-1:0] q_reg   [0:STEPS];
    logic [DV_W-1:0]  dv_reg  [0:STEPS];
    logic             neg_reg [0:STEPS];

    assign mul_s = {1'b0, mul};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= val * mul_s;
            m_div_reg <= div;
        end
    end

    assign prod_mag = prod_reg[PROD_W-1] ? (~prod_reg + 1'b1) : prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {prod_mag, 1'b0} + {{(REM_W - lbat_pkg::EXT_W){1'b0}}, m_div_reg};
            q_reg[0]   <= '0;
            dv_reg[0]  <= {m_div_reg, 1'b0};
            neg_reg[0] <= prod_reg[PROD_W-1];
        end
    end

    for (genvar i = 1; i <= STEPS; i++)
    begin : g_div
        localparam int K = STEPS - i;
        logic [CMP_W-1:0] sub;
        logic [CMP_W-1:0] rem_x;
        logic             take;

        assign sub   = {{STEPS{1'b0}}, dv_reg[i-1]} << K;
        assign rem_x = {{(CMP_W - REM_W){1'b0}}, rem_reg[i-1]};
        assign take  = (rem_x >= sub);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? REM_W'(rem_x - sub) : rem_reg[i-1];
                q_reg[i]   <= q_reg[i-1] | (STEPS'(take) << K);
                dv_reg[i]  <= dv_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    assign mag = q_reg[STEPS];
    assign neg = neg_reg[STEPS];

endmodule

[design/layer_box_at_time.sv]
`timescale 1ns / 1ps
// Layer bounding box at the timeline cursor. A layer is taken in every cycle
// unless the pipeline holds, and its box, if any, reaches the output through
// 55 register stages (two input stages, an 18-stage interpolation divider,
// a 34-stage scaling divider, one output register); one bit of quotient per
// stage sets that depth. The whole pipeline moves together and holds only
// while a box waits at the output. The user must write configuration only
// while idle; the block does not enforce it. Layers outside the cursor time,
// of a skipped type or of zero scaled width leave a bubble, no transaction.

module layer_box_at_time (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic        [lbat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [lbat_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic        [7:0]                      layer_index,
    input  logic        [2:0]                      layer_kind,
    input  logic        [lbat_pkg::TIME_W-1:0]     start_ms,
    input  logic        [lbat_pkg::TIME_W-1:0]     duration_ms,
    input  logic        [lbat_pkg::TIME_W-1:0]     fade_in_ms,
    input  logic        [lbat_pkg::TIME_W-1:0]     fade_out_ms,
    input  logic signed [lbat_pkg::POS_W-1:0]      from_x,
    input  logic signed [lbat_pkg::POS_W-1:0]      from_y,
    input  logic signed [lbat_pkg::POS_W-1:0]      to_x,
    input  logic signed [lbat_pkg::POS_W-1:0]      to_y,
    input  logic        [lbat_pkg::EXT_W-1:0]      obj_width,
    input  logic        [lbat_pkg::EXT_W-1:0]      obj_height,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic        [7:0]                      out_layer,
    output logic signed [lbat_pkg::BOX_W-1:0]      box_x,
    output logic signed [lbat_pkg::BOX_W-1:0]      box_y,
    output logic        [lbat_pkg::BOX_W-1:0]      box_w,
    output logic        [lbat_pkg::BOX_W-1:0]      box_h
);

    typedef struct packed {
        logic [7:0]                    layer;
        logic [lbat_pkg::EXT_W-1:0]    w;
        logic [lbat_pkg::EXT_W-1:0]    h;
    } line1_t;

    typedef struct packed {
        logic [7:0] layer;
    } line2_t;

    logic [lbat_pkg::EXT_W-1:0]  project_w_reg;
    logic [lbat_pkg::EXT_W-1:0]  project_h_reg;
    logic [lbat_pkg::EXT_W-1:0]  view_w_reg;
    logic [lbat_pkg::EXT_W-1:0]  view_h_reg;
    logic [lbat_pkg::TIME_W-1:0] cursor_reg;

    logic en;

    logic                               s1_vld_reg;
    logic [7:0]                         s1_layer_reg;
    logic [2:0]                         s1_type_reg;
    logic [lbat_pkg::TIME_W-1:0]        s1_start_reg;
    logic [lbat_pkg::SPAN_W-1:0]        s1_span_reg;
    logic signed [lbat_pkg::POS_W-1:0]  s1_fx_reg, s1_fy_reg, s1_tx_reg, s1_ty_reg;
    logic [lbat_pkg::EXT_W-1:0]         s1_w_reg, s1_h_reg;

    logic                               s2_vld_reg;
    logic [7:0]                         s2_layer_reg;
    logic [lbat_pkg::TIME_W-1:0]        s2_t_reg;
    logic [lbat_pkg::SPAN_W-1:0]        s2_span_reg;
    logic signed [lbat_pkg::POS_W-1:0]  s2_fx_reg, s2_fy_reg, s2_tx_reg, s2_ty_reg;
    logic [lbat_pkg::EXT_W-1:0]         s2_w_reg, s2_h_reg;

    logic                               type_ok;
    logic [lbat_pkg::TIME_W:0]          t_diff;
    logic                               in_window;

    logic signed [lbat_pkg::POS_W-1:0]  pos_x, pos_y;
    line1_t line1_reg     [0:lbat_pkg::INTERP_LAT-1];
    logic   line1_vld_reg [0:lbat_pkg::INTERP_LAT-1];
    line2_t line2_reg     [0:lbat_pkg::SCALE_LAT-1];
    logic   line2_vld_reg [0:lbat_pkg::SCALE_LAT-1];

    logic [lbat_pkg::EXT_W-1:0]  pw, ph;
    logic [lbat_pkg::BOX_W-1:0]  qx, qy, qw, qh;
    logic                        nx, ny, nw, nh;
    logic signed [lbat_pkg::BOX_W:0] sx, sy;
    logic signed [lbat_pkg::BOX_W-1:0] box_x_next, box_y_next;
    logic [lbat_pkg::BOX_W-1:0]  box_w_next, box_h_next;

    logic                              out_valid_reg;
    logic [7:0]                        out_layer_reg;
    logic signed [lbat_pkg::BOX_W-1:0] box_x_reg, box_y_reg;
    logic [lbat_pkg::BOX_W-1:0]        box_w_reg, box_h_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            project_w_reg <= lbat_pkg::EXT_W'(1);
            project_h_reg <= lbat_pkg::EXT_W'(1);
            view_w_reg    <= lbat_pkg::EXT_W'(1);
            view_h_reg    <= lbat_pkg::EXT_W'(1);
            cursor_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lbat_pkg::REG_PROJECT_W: project_w_reg <= cfg_data[lbat_pkg::EXT_W-1:0];
                lbat_pkg::REG_PROJECT_H: project_h_reg <= cfg_data[lbat_pkg::EXT_W-1:0];
                lbat_pkg::REG_VIEW_W:    view_w_reg    <= cfg_data[lbat_pkg::EXT_W-1:0];
                lbat_pkg::REG_VIEW_H:    view_h_reg    <= cfg_data[lbat_pkg::EXT_W-1:0];
                lbat_pkg::REG_CURSOR:    cursor_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: capture and total span
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_layer_reg <= layer_index;
            s1_type_reg  <= layer_kind;
            s1_start_reg <= start_ms;
            s1_span_reg  <= lbat_pkg::SPAN_W'(duration_ms) + lbat_pkg::SPAN_W'(fade_in_ms)
                          + lbat_pkg::SPAN_W'(fade_out_ms);
            s1_fx_reg    <= from_x;
            s1_fy_reg    <= from_y;
            s1_tx_reg    <= to_x;
            s1_ty_reg    <= to_y;
            s1_w_reg     <= obj_width;
            s1_h_reg     <= obj_height;
        end
    end

    // stage 2: time window and type filter
    always_comb
    begin
        unique case (s1_type_reg)
            lbat_pkg::OBJ_IMAGE,
            lbat_pkg::OBJ_HIGHLIGHT,
            lbat_pkg::OBJ_MOUSE,
            lbat_pkg::OBJ_TEXT: type_ok = 1'b1;
            default:            type_ok = 1'b0;
        endcase
    end

    assign t_diff    = {1'b0, cursor_reg} - {1'b0, s1_start_reg};
    assign in_window = !t_diff[lbat_pkg::TIME_W]
                    && ({2'b00, t_diff[lbat_pkg::TIME_W-1:0]} <= s1_span_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg <= s1_vld_reg && type_ok && in_window;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_layer_reg <= s1_layer_reg;
            s2_t_reg     <= t_diff[lbat_pkg::TIME_W-1:0];
            s2_span_reg  <= s1_span_reg;
            s2_fx_reg    <= s1_fx_reg;
            s2_fy_reg    <= s1_fy_reg;
            s2_tx_reg    <= s1_tx_reg;
            s2_ty_reg    <= s1_ty_reg;
            s2_w_reg     <= s1_w_reg;
            s2_h_reg     <= s1_h_reg;
        end
    end

    lbat_interp u_interp_x (
        .clk  (clk),
        .en   (en),
        .a    (s2_fx_reg),
        .b    (s2_tx_reg),
        .t    (s2_t_reg),
        .span (s2_span_reg),
        .pos  (pos_x)
    );

    lbat_interp u_interp_y (
        .clk  (clk),
        .en   (en),
        .a    (s2_fy_reg),
        .b    (s2_ty_reg),
        .t    (s2_t_reg),
        .span (s2_span_reg),
        .pos  (pos_y)
    );

    // side line alongside the interpolation dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lbat_pkg::INTERP_LAT; i++)
            begin
                line1_vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            line1_vld_reg[0] <= s2_vld_reg;
            for (int i = 1; i < lbat_pkg::INTERP_LAT; i++)
            begin
                line1_vld_reg[i] <= line1_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line1_reg[0].layer <= s2_layer_reg;
            line1_reg[0].w     <= s2_w_reg;
            line1_reg[0].h     <= s2_h_reg;
            for (int i = 1; i < lbat_pkg::INTERP_LAT; i++)
            begin
                line1_reg[i] <= line1_reg[i-1];
            end
        end
    end

    // a zero project extent counts as one
    assign pw = (project_w_reg == '0) ? lbat_pkg::EXT_W'(1) : project_w_reg;
    assign ph = (project_h_reg == '0) ? lbat_pkg::EXT_W'(1) : project_h_reg;

    lbat_scale u_scale_x (
        .clk (clk),
        .en  (en),
        .val ({pos_x[lbat_pkg::POS_W-1], pos_x}),
        .mul (view_w_reg),
        .div (pw),
        .mag (qx),
        .neg (nx)
    );

    lbat_scale u_scale_y (
        .clk (clk),
        .en  (en),
        .val ({pos_y[lbat_pkg::POS_W-1], pos_y}),
        .mul (view_h_reg),
        .div (ph),
        .mag (qy),
        .neg (ny)
    );

    lbat_scale u_scale_w (
        .clk (clk),
        .en  (en),
        .val ({1'b0, line1_reg[lbat_pkg::INTERP_LAT-1].w}),
        .mul (view_w_reg),
        .div (pw),
        .mag (qw),
        .neg (nw)
    );

    lbat_scale u_scale_h (
        .clk (clk),
        .en  (en),
        .val ({1'b0, line1_reg[lbat_pkg::INTERP_LAT-1].h}),
        .mul (view_h_reg),
        .div (ph),
        .mag (qh),
        .neg (nh)
    );

    // side line alongside the scaling dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lbat_pkg::SCALE_LAT; i++)
            begin
                line2_vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            line2_vld_reg[0] <= line1_vld_reg[lbat_pkg::INTERP_LAT-1];
            for (int i = 1; i < lbat_pkg::SCALE_LAT; i++)
            begin
                line2_vld_reg[i] <= line2_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line2_reg[0].layer <= line1_reg[lbat_pkg::INTERP_LAT-1].layer;
            for (int i = 1; i < lbat_pkg::SCALE_LAT; i++)
            begin
                line2_reg[i] <= line2_reg[i-1];
            end
        end
    end

    // sign and saturation
    assign sx = nx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign sy = ny ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

    always_comb
    begin
        priority if (sx > $signed({2'b00, {(lbat_pkg::BOX_W-1){1'b1}}}))
            box_x_next = {1'b0, {(lbat_pkg::BOX_W-1){1'b1}}};
        else if (sx < $signed({2'b11, {(lbat_pkg::BOX_W-1){1'b0}}}))
            box_x_next = {1'b1, {(lbat_pkg::BOX_W-1){1'b0}}};
        else
            box_x_next = sx[lbat_pkg::BOX_W-1:0];

        priority if (sy > $signed({2'b00, {(lbat_pkg::BOX_W-1){1'b1}}}))
            box_y_next = {1'b0, {(lbat_pkg::BOX_W-1){1'b1}}};
        else if (sy < $signed({2'b11, {(lbat_pkg::BOX_W-1){1'b0}}}))
            box_y_next = {1'b1, {(lbat_pkg::BOX_W-1){1'b0}}};
        else
            box_y_next = sy[lbat_pkg::BOX_W-1:0];
    end

    assign box_w_next = nw ? '0 : qw;
    assign box_h_next = nh ? '0 : qh;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= line2_vld_reg[lbat_pkg::SCALE_LAT-1] && (box_w_next != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_layer_reg <= line2_reg[lbat_pkg::SCALE_LAT-1].layer;
            box_x_reg     <= box_x_next;
            box_y_reg     <= box_y_next;
            box_w_reg     <= box_w_next;
            box_h_reg     <= box_h_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_layer = out_layer_reg;
    assign box_x     = box_x_reg;
    assign box_y     = box_y_reg;
    assign box_w     = box_w_reg;
    assign box_h     = box_h_reg;

    a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> box_w != '0)
        else $error("box emitted with zero width");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready ##1 (out_valid && $stable(out_layer)
            && $stable(box_x) && $stable(box_y) && $stable(box_w) && $stable(box_h)))
        else $error("pipeline advanced while a box was waiting");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(line2_vld_reg[lbat_pkg::SCALE_LAT-1]))
        else $error("box appeared without a transaction behind it");

endmodule

[bench/lbat_box_checker.sv]
`timescale 1ns / 1ps
// lbat_box_checker: watches the layer and box channels of layer_box_at_time,
// predicts the box of every accepted layer and compares; depends on lbat_pkg

module lbat_box_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [lbat_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lbat_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [7:0]                           layer_index,
    input  logic [2:0]                           layer_kind,
    input  logic [lbat_pkg::TIME_W-1:0]          start_ms,
    input  logic [lbat_pkg::TIME_W-1:0]          duration_ms,
    input  logic [lbat_pkg::TIME_W-1:0]          fade_in_ms,
    input  logic [lbat_pkg::TIME_W-1:0]          fade_out_ms,
    input  logic signed [lbat_pkg::POS_W-1:0]    from_x,
    input  logic signed [lbat_pkg::POS_W-1:0]    from_y,
    input  logic signed [lbat_pkg::POS_W-1:0]    to_x,
    input  logic signed [lbat_pkg::POS_W-1:0]    to_y,
    input  logic [lbat_pkg::EXT_W-1:0]           obj_width,
    input  logic [lbat_pkg::EXT_W-1:0]           obj_height,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [7:0]                           out_layer,
    input  logic signed [lbat_pkg::BOX_W-1:0]    box_x,
    input  logic signed [lbat_pkg::BOX_W-1:0]    box_y,
    input  logic [lbat_pkg::BOX_W-1:0]           box_w,
    input  logic [lbat_pkg::BOX_W-1:0]           box_h,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   box_count
);

    typedef struct packed {
        logic [7:0]                  layer;
        logic [lbat_pkg::BOX_W-1:0]  x;
        logic [lbat_pkg::BOX_W-1:0]  y;
        logic [lbat_pkg::BOX_W-1:0]  w;
        logic [lbat_pkg::BOX_W-1:0]  h;
    } box_t;

    box_t boxes_due[$];

    logic [lbat_pkg::EXT_W-1:0]  proj_w_q, proj_h_q, view_w_q, view_h_q;
    logic [lbat_pkg::TIME_W-1:0] cursor_q;

    function automatic longint scale_round(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag * 2 + den) / (den * 2);
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic [lbat_pkg::BOX_W-1:0] clamp_s32(longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[lbat_pkg::BOX_W-1:0];
    endfunction

    function automatic logic [lbat_pkg::BOX_W-1:0] clamp_u32(longint v);
        if (v < 0)
            return '0;
        if (v > 64'sd4294967295)
            return '1;
        return v[lbat_pkg::BOX_W-1:0];
    endfunction

    function automatic longint lerp_pos(longint a, longint b, longint t, longint span);
        if (span == 0)
            return a;
        return (a * (span - t) + b * t) / span;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proj_w_q <= lbat_pkg::EXT_W'(1);
            proj_h_q <= lbat_pkg::EXT_W'(1);
            view_w_q <= lbat_pkg::EXT_W'(1);
            view_h_q <= lbat_pkg::EXT_W'(1);
            cursor_q <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lbat_pkg::REG_PROJECT_W: proj_w_q <= cfg_data[lbat_pkg::EXT_W-1:0];
                lbat_pkg::REG_PROJECT_H: proj_h_q <= cfg_data[lbat_pkg::EXT_W-1:0];
                lbat_pkg::REG_VIEW_W:    view_w_q <= cfg_data[lbat_pkg::EXT_W-1:0];
                lbat_pkg::REG_VIEW_H:    view_h_q <= cfg_data[lbat_pkg::EXT_W-1:0];
                lbat_pkg::REG_CURSOR:    cursor_q <= cfg_data[lbat_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // layer side: predict
    always @(posedge clk)
    begin
        longint t0, t_end, now, px, py, pw, ph, bw, bh;
        box_t b;
        if (rst_n && in_valid && in_ready)
        begin
            t0 = longint'(start_ms);
            t_end = t0 + longint'(duration_ms) + longint'(fade_in_ms) + longint'(fade_out_ms);
            now = longint'(cursor_q);
            if (now >= t0 && now <= t_end && (layer_kind == lbat_pkg::OBJ_IMAGE ||
                layer_kind == lbat_pkg::OBJ_HIGHLIGHT || layer_kind == lbat_pkg::OBJ_MOUSE ||
                layer_kind == lbat_pkg::OBJ_TEXT))
            begin
                px = lerp_pos(longint'(from_x), longint'(to_x), now - t0, t_end - t0);
                py = lerp_pos(longint'(from_y), longint'(to_y), now - t0, t_end - t0);
                pw = (proj_w_q == '0) ? 1 : longint'(proj_w_q);
                ph = (proj_h_q == '0) ? 1 : longint'(proj_h_q);
                bw = scale_round(longint'(obj_width) * longint'(view_w_q), pw);
                bh = scale_round(longint'(obj_height) * longint'(view_h_q), ph);
                if (clamp_u32(bw) != '0)
                begin
                    b.layer = layer_index;
                    b.x = clamp_s32(scale_round(px * longint'(view_w_q), pw));
                    b.y = clamp_s32(scale_round(py * longint'(view_h_q), ph));
                    b.w = clamp_u32(bw);
                    b.h = clamp_u32(bh);
                    boxes_due.push_back(b);
                end
            end
        end
    end

    // box side: compare
    always @(posedge clk)
    begin
        box_t e;
        if (rst_n && out_valid && out_ready)
        begin
            box_count <= box_count + 1;
            if (boxes_due.size() == 0)
            begin
                $display("%0t: unexpected box transaction layer=%0d", $time, out_layer);
                fail_count <= fail_count + 1;
            end
            else
            begin
                e = boxes_due.pop_front();
                if (e.layer !== out_layer || e.x !== box_x || e.y !== box_y ||
                    e.w !== box_w || e.h !== box_h)
                begin
                    $display("%0t: box mismatch expected layer=%0d x=%0d y=%0d w=%0d h=%0d",
                             $time, e.layer, $signed(e.x), $signed(e.y), e.w, e.h);
                    $display("%0t:              actual layer=%0d x=%0d y=%0d w=%0d h=%0d",
                             $time, out_layer, box_x, box_y, box_w, box_h);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    initial
    begin
        fail_count = 0;
        box_count = 0;
        pending = 0;
    end

    always @(posedge clk)
        pending <= boxes_due.size();

endmodule

[bench/layer_box_at_time_tb.sv]
`timescale 1ns / 1ps
// layer_box_at_time_tb: drives layers and configuration into layer_box_at_time
// under varying idle patterns; depends on lbat_pkg and lbat_box_checker

module layer_box_at_time_tb;

    typedef struct {
        logic [7:0]                  idx;
        logic [2:0]                  kind;
        logic [lbat_pkg::TIME_W-1:0] t_start, t_dur, t_in, t_out;
        logic [lbat_pkg::POS_W-1:0]  fx, fy, tx, ty;
        logic [lbat_pkg::EXT_W-1:0]  w, h;
    } layer_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic [lbat_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lbat_pkg::CFG_DAT_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic [7:0] layer_index = '0;
    logic [2:0] layer_kind = '0;
    logic [lbat_pkg::TIME_W-1:0] start_ms = '0, duration_ms = '0;
    logic [lbat_pkg::TIME_W-1:0] fade_in_ms = '0, fade_out_ms = '0;
    logic signed [lbat_pkg::POS_W-1:0] from_x = '0, from_y = '0, to_x = '0, to_y = '0;
    logic [lbat_pkg::EXT_W-1:0] obj_width = '0, obj_height = '0;
    logic out_valid;
    logic out_ready = 0;
    logic [7:0] out_layer;
    logic signed [lbat_pkg::BOX_W-1:0] box_x, box_y;
    logic [lbat_pkg::BOX_W-1:0] box_w, box_h;

    int fail_count, pending, box_count;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_rx = 0;
    int phase_id = -1;
    int layers_sent = 0;
    int quiet_cycles = 0;
    logic [lbat_pkg::TIME_W-1:0] cur;

    always #5 clk = ~clk;

    layer_box_at_time i_dut (.*);

    lbat_box_checker i_checker (.*);

    always @(posedge clk)
        out_ready <= hold_rx ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);

    // long receiver hold-off so the pipeline backs up into the input
    initial
    begin
        wait (phase_id == 2);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk);
        hold_rx <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000)
        begin
            $display("watchdog expired, pending=%0d", pending);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_regs(input logic [lbat_pkg::EXT_W-1:0] pw, ph, vw, vh,
                              input logic [lbat_pkg::TIME_W-1:0] cursor);
        logic [lbat_pkg::CFG_IDX_W-1:0] regs [5];
        logic [lbat_pkg::CFG_DAT_W-1:0] vals [5];
        regs = '{lbat_pkg::REG_PROJECT_W, lbat_pkg::REG_PROJECT_H, lbat_pkg::REG_VIEW_W,
                 lbat_pkg::REG_VIEW_H, lbat_pkg::REG_CURSOR};
        vals = '{lbat_pkg::CFG_DAT_W'(pw), lbat_pkg::CFG_DAT_W'(ph),
                 lbat_pkg::CFG_DAT_W'(vw), lbat_pkg::CFG_DAT_W'(vh),
                 lbat_pkg::CFG_DAT_W'(cursor)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        cur = cursor;
        @(posedge clk);
    endtask

    task automatic send(input layer_t l);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        layer_index <= l.idx;
        layer_kind <= l.kind;
        start_ms <= l.t_start;
        duration_ms <= l.t_dur;
        fade_in_ms <= l.t_in;
        fade_out_ms <= l.t_out;
        from_x <= l.fx;
        from_y <= l.fy;
        to_x <= l.tx;
        to_y <= l.ty;
        obj_width <= l.w;
        obj_height <= l.h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        layers_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic layer_t mk(logic [2:0] kind,
                                  logic [lbat_pkg::TIME_W-1:0] s, d, fi, fo,
                                  logic [lbat_pkg::POS_W-1:0] fx, fy, tx, ty,
                                  logic [lbat_pkg::EXT_W-1:0] w, h);
        layer_t l;
        l.idx = 8'($urandom);
        l.kind = kind;
        l.t_start = s;
        l.t_dur = d;
        l.t_in = fi;
        l.t_out = fo;
        l.fx = fx;
        l.fy = fy;
        l.tx = tx;
        l.ty = ty;
        l.w = w;
        l.h = h;
        return l;
    endfunction

    function automatic logic [lbat_pkg::TIME_W-1:0] rnd_time();
        return lbat_pkg::TIME_W'($urandom >> $urandom_range(31, 8));
    endfunction

    function automatic layer_t rand_layer();
        layer_t l;
        logic [2:0] good [4];
        longint k;
        good = '{lbat_pkg::OBJ_IMAGE, lbat_pkg::OBJ_HIGHLIGHT, lbat_pkg::OBJ_MOUSE,
                 lbat_pkg::OBJ_TEXT};
        l = mk(($urandom_range(3) == 0) ? 3'($urandom_range(7)) : good[$urandom_range(3)],
               rnd_time(), rnd_time(), rnd_time(), rnd_time(),
               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom >> $urandom_range(31, 16)),
               16'($urandom >> $urandom_range(31, 16)));
        if ($urandom_range(9) < 8)
        begin
            k = longint'(rnd_time()) % (longint'(cur) + 1);
            l.t_start = lbat_pkg::TIME_W'(longint'(cur) - k);
            if (longint'(l.t_dur) + longint'(l.t_in) + longint'(l.t_out) < k)
                l.t_dur = lbat_pkg::TIME_W'(k);
            if ($urandom_range(19) == 0)
            begin
                l.t_start = cur;
                l.t_dur = '0;
                l.t_in = '0;
                l.t_out = '0;
            end
        end
        return l;
    endfunction

    initial
    begin
        logic [lbat_pkg::EXT_W-1:0] cfg_tab [7][4];
        logic [lbat_pkg::TIME_W-1:0] cur_tab [7];
        int n_items;
        cfg_tab = '{'{16'd1, 16'd1, 16'd1, 16'd1},
                    '{16'd65535, 16'd65535, 16'd65535, 16'd65535},
                    '{16'd3, 16'd7, 16'd5, 16'd2},
                    '{16'd1, 16'd1, 16'd65535, 16'd65535},
                    '{16'd65535, 16'd40000, 16'd1, 16'd3},
                    '{16'd0, 16'd0, 16'd9, 16'd0},
                    '{16'd5, 16'd5, 16'd0, 16'd5}};
        cur_tab = '{24'($urandom), 24'hFFFFFF, 24'd0, 24'($urandom), 24'($urandom),
                    24'($urandom), 24'($urandom)};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        write_regs(16'd3, 16'd7, 16'd5, 16'd2, 24'd1000);
        for (int k = 0; k < 8; k++)
            send(mk(3'(k), 24'd500, 24'd1000, 24'd0, 24'd0,
                    16'd100, -16'sd100, 16'd300, 16'd50, 16'd10, 16'd10));
        send(mk(lbat_pkg::OBJ_IMAGE, 24'd1000, 24'd0, 24'd0, 24'd0,
                16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
        send(mk(lbat_pkg::OBJ_TEXT, 24'd1001, 24'd5, 24'd5, 24'd5,
                16'd1, 16'd1, 16'd1, 16'd1, 16'd5, 16'd5));
        send(mk(lbat_pkg::OBJ_TEXT, 24'd0, 24'd999, 24'd0, 24'd0,
                16'd1, 16'd1, 16'd1, 16'd1, 16'd5, 16'd5));
        send(mk(lbat_pkg::OBJ_MOUSE, 24'd0, 24'd1000, 24'd0, 24'd0,
                16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd5, 16'd0));
        send(mk(lbat_pkg::OBJ_HIGHLIGHT, 24'd0, 24'd400, 24'd300, 24'd300,
                16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'd0, 16'd9));
        send(mk(lbat_pkg::OBJ_IMAGE, 24'd999, 24'd1, 24'd0, 24'd0,
                -16'sd7, 16'd7, 16'd9, -16'sd9, 16'd1, 16'd1));
        send(mk(lbat_pkg::OBJ_IMAGE, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                -16'sd1, 16'd1, 16'd3, -16'sd3, 16'd3, 16'd1));
        send(mk(lbat_pkg::OBJ_IMAGE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1));
        send(mk(lbat_pkg::OBJ_MOUSE, 24'd200, 24'd300, 24'd200, 24'd300,
                16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
        drain();

        for (int p = 0; p < 7; p++)
        begin
            tx_idle_pct = (p < 2) ? 7 : (p < 4) ? 49 : 0;
            rx_idle_pct = (p < 2) ? 49 : (p < 4) ? 7 : 0;
            write_regs(cfg_tab[p][0], cfg_tab[p][1], cfg_tab[p][2], cfg_tab[p][3], cur_tab[p]);
            phase_id = p;
            n_items = (p == 6) ? 40 : 265;
            for (int i = 0; i < n_items; i++)
                send(rand_layer());
            drain();
        end

        $display("covered %0d layers in 8 register settings, %0d boxes checked",
                 layers_sent, box_count);
        $display("idle patterns: sender-light, receiver-light, none, plus one long output stall");
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
